// ----- sv/trdf_pkg.sv -----
// Shared types and constants for the tape image record deframer.
`default_nettype none
package trdf_pkg;

  // Width of the payload byte counter; lengths above its range are too long
  localparam int LENGTH_BITS = 32;
  localparam int LEN_W       = 32;
  localparam logic [LEN_W:0] LEN_LIMIT = {{(LEN_W + 1 - LENGTH_BITS){1'b0}},
                                          {LENGTH_BITS{1'b1}}};

  // Result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic CFG_PAD_ODD = 1'b0;
  localparam logic CFG_MAX_LEN = 1'b1;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd65535;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_MARK    = 3'd2,
    KIND_TOOLONG = 3'd3,
    KIND_CORRUPT = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] record_length;
    logic             last_payload;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/trdf_parse.sv -----
// Front part: accepts stream bytes, tracks record framing and classifies results.
`default_nettype none
module trdf_parse (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire logic                    cfg_addr,
  input  wire logic [31:0]             cfg_wdata,
  input  wire logic                    byte_valid,
  input  wire logic [7:0]              byte_data,
  output      logic                    res_valid,
  output      trdf_pkg::result_t       res
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_PAD,
    PH_TRAILER
  } phase_t;

  phase_t                            phase_r, phase_nxt;
  logic [1:0]                        idx_r, idx_nxt;
  logic [trdf_pkg::LEN_W-1:0]        lead_r, lead_nxt;
  logic [trdf_pkg::LEN_W-1:0]        trail_r, trail_nxt;
  logic [trdf_pkg::LENGTH_BITS-1:0]  rem_r, rem_nxt;
  logic                              halted_r, halted_nxt;
  logic                              pad_odd_r;
  logic [trdf_pkg::LEN_W-1:0]        max_len_r;

  logic [trdf_pkg::LEN_W-1:0]        field_full;
  logic [trdf_pkg::LENGTH_BITS-1:0]  rem_dec;
  logic                              too_long;

  // Complete length field once its top byte arrives
  assign field_full = (phase_r == PH_HEADER) ? {byte_data, lead_r[23:0]}
                                             : {byte_data, trail_r[23:0]};
  assign rem_dec    = rem_r - {{(trdf_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};
  assign too_long   = (field_full > max_len_r) ||
                      ({1'b0, field_full} > trdf_pkg::LEN_LIMIT);

  // Advance framing on each accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    lead_nxt   = lead_r;
    trail_nxt  = trail_r;
    rem_nxt    = rem_r;
    halted_nxt = halted_r;
    res_valid  = 1'b0;
    res        = '{kind: trdf_pkg::KIND_DATA, payload_byte: 8'd0,
                   record_length: '0, last_payload: 1'b0};
    if (byte_valid && !halted_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          unique case (idx_r)
            2'd0: lead_nxt[7:0]   = byte_data;
            2'd1: lead_nxt[15:8]  = byte_data;
            2'd2: lead_nxt[23:16] = byte_data;
            2'd3: lead_nxt[31:24] = byte_data;
            default: lead_nxt = lead_r;
          endcase
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            if (field_full == '0) begin
              res_valid = 1'b1;
              res.kind  = trdf_pkg::KIND_MARK;
            end else if (too_long) begin
              halted_nxt        = 1'b1;
              res_valid         = 1'b1;
              res.kind          = trdf_pkg::KIND_TOOLONG;
              res.record_length = field_full;
            end else begin
              rem_nxt   = field_full[trdf_pkg::LENGTH_BITS-1:0];
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          rem_nxt          = rem_dec;
          res_valid        = 1'b1;
          res.payload_byte = byte_data;
          if (rem_dec == '0) begin
            res.last_payload = 1'b1;
            idx_nxt          = 2'd0;
            phase_nxt        = (pad_odd_r && lead_r[0]) ? PH_PAD : PH_TRAILER;
          end
        end
        PH_PAD: begin
          idx_nxt   = 2'd0;
          phase_nxt = PH_TRAILER;
        end
        PH_TRAILER: begin
          unique case (idx_r)
            2'd0: trail_nxt[7:0]   = byte_data;
            2'd1: trail_nxt[15:8]  = byte_data;
            2'd2: trail_nxt[23:16] = byte_data;
            2'd3: trail_nxt[31:24] = byte_data;
            default: trail_nxt = trail_r;
          endcase
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            phase_nxt = PH_HEADER;
            res_valid = 1'b1;
            if (field_full != lead_r) begin
              halted_nxt = 1'b1;
              res.kind   = trdf_pkg::KIND_CORRUPT;
            end else begin
              res.kind          = trdf_pkg::KIND_DONE;
              res.record_length = lead_r;
            end
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
          idx_nxt   = 2'd0;
        end
      endcase
    end
  end

  // Hold framing state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      idx_r     <= 2'd0;
      lead_r    <= '0;
      trail_r   <= '0;
      rem_r     <= '0;
      halted_r  <= 1'b0;
      pad_odd_r <= 1'b0;
      max_len_r <= trdf_pkg::MAX_LEN_RESET;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      lead_r   <= lead_nxt;
      trail_r  <= trail_nxt;
      rem_r    <= rem_nxt;
      halted_r <= halted_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          trdf_pkg::CFG_PAD_ODD: pad_odd_r <= cfg_wdata[0];
          trdf_pkg::CFG_MAX_LEN: max_len_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/trdf_queue.sv -----
// Back part: short result queue that drives the output channel.
`default_nettype none
module trdf_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire trdf_pkg::result_t   push_data,
  output      logic                full,
  output      logic                pop_valid,
  input  wire logic                pop_ready,
  output      trdf_pkg::result_t   pop_data
);

  trdf_pkg::result_t                 mem_r [trdf_pkg::QUEUE_DEPTH];
  logic [trdf_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [trdf_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [trdf_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                              pop;

  assign full      = (count_r == trdf_pkg::QCNT_W'(trdf_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store result items
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tape_image_record_deframer.sv -----
// Top level: tape image record deframer, byte stream in, framed result items out.
// Result items are registered into the result queue and offered on out_ in order.
// Throughput: one byte per cycle while the four-entry result queue is not full;
// the queue decouples the output side. in_tready drops only while the queue is full.
// Reset (rst_n low, synchronous): framing restarts at a header, the halt flag clears,
// registers return to pad off and maximum length 65535, and the queue empties.
`default_nettype none
module tape_image_record_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // [7:0] payload_byte, [39:8] record_length
  output      logic [2:0]  out_tuser,  // [2:0] result_kind
  output      logic        out_tlast   // last_payload
);

  logic               q_full;
  logic               res_valid;
  trdf_pkg::result_t  res;
  trdf_pkg::result_t  head;

  assign in_tready = !q_full;

  // Parse accepted bytes
  trdf_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (in_tvalid && in_tready),
    .byte_data  (in_tdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Queue results toward the output
  trdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (q_full),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (head)
  );

  assign out_tdata = {head.record_length, head.payload_byte};
  assign out_tuser = head.kind;
  assign out_tlast = head.last_payload;

endmodule
`default_nettype wire
